/* sv/mwsl_pkg.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel speed limiter package
// Shared widths and the request record types that travel down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsl_pkg;

  localparam int SPEED_BITS = 16;
  localparam int WHEEL_W    = SPEED_BITS + 2;   // one wheel speed, signed
  localparam int MAG_W      = SPEED_BITS + 1;   // magnitude of one wheel speed
  localparam int LIMIT_W    = 17;               // limit register width
  localparam int QUOT_W     = LIMIT_W;          // scaled magnitude never exceeds the limit
  localparam int PROD_W     = MAG_W + LIMIT_W;  // magnitude times limit
  localparam int NUM_WHEELS = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(98304);

  // Wheel order: front right, front left, rear left, rear right.
  localparam int WHEEL_FR = 0;
  localparam int WHEEL_FL = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  typedef logic signed [WHEEL_W-1:0] wheel_t;
  typedef logic [MAG_W-1:0]          mag_t;

  // Output of the mixing and peak search stages.
  typedef struct packed {
    logic                          valid;
    logic                          scaled;
    mag_t                          peak;
    wheel_t [NUM_WHEELS-1:0]       wheel;
    mag_t   [NUM_WHEELS-1:0]       mag;
  } mix_out_t;

  // One wheel inside the divider.
  typedef struct packed {
    logic              neg;
    wheel_t            wheel;
    logic [MAG_W-1:0]  rem;
    logic [QUOT_W-1:0] dq;    // dividend bits shift out the top, quotient bits in the bottom
  } div_lane_t;

  typedef struct packed {
    logic                         valid;
    logic                         scaled;
    mag_t                         peak;
    div_lane_t [NUM_WHEELS-1:0]   lane;
  } div_stage_t;

endpackage

`default_nettype wire

/* sv/mwsl_mix.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel mixing and peak search
// Three register stages: wheel sums, magnitudes with pairwise maximum, then the
// overall peak and its compare against the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsl_mix (
  input  wire                                logic clk,
  input  wire                                logic rst,
  input  wire                                logic in_valid,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_forward,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_sideways,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_rotate,
  input  wire  logic [mwsl_pkg::LIMIT_W-1:0]           limit,
  output mwsl_pkg::mix_out_t                           mix_out
);
  import mwsl_pkg::*;

  // Stage 1
  logic                    s1_valid;
  wheel_t [NUM_WHEELS-1:0] s1_wheel;
  // Stage 2
  logic                    s2_valid;
  wheel_t [NUM_WHEELS-1:0] s2_wheel;
  mag_t   [NUM_WHEELS-1:0] s2_mag;
  mag_t                    s2_max_front;
  mag_t                    s2_max_rear;

  wheel_t                  fwd;
  wheel_t                  side;
  wheel_t                  rot;
  wheel_t [NUM_WHEELS-1:0] wheel_next;
  mag_t   [NUM_WHEELS-1:0] mag_next;
  mag_t                    peak_next;

  assign fwd  = WHEEL_W'(speed_forward);
  assign side = WHEEL_W'(speed_sideways);
  assign rot  = WHEEL_W'(speed_rotate);

  always_comb begin
    wheel_next[WHEEL_FR] = -fwd - side - rot;
    wheel_next[WHEEL_FL] =  fwd - side - rot;
    wheel_next[WHEEL_RL] =  fwd + side - rot;
    wheel_next[WHEEL_RR] = -fwd + side - rot;
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag_next[i] = s1_wheel[i][WHEEL_W-1] ? MAG_W'(-s1_wheel[i]) : MAG_W'(s1_wheel[i]);
    end
  end

  assign peak_next = (s2_max_front > s2_max_rear) ? s2_max_front : s2_max_rear;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      mix_out.valid <= 1'b0;
    end else begin
      s1_valid      <= in_valid;
      s2_valid      <= s1_valid;
      mix_out.valid <= s2_valid;
    end
    s1_wheel     <= wheel_next;
    s2_wheel     <= s1_wheel;
    s2_mag       <= mag_next;
    s2_max_front <= (mag_next[WHEEL_FR] > mag_next[WHEEL_FL]) ? mag_next[WHEEL_FR]
                                                              : mag_next[WHEEL_FL];
    s2_max_rear  <= (mag_next[WHEEL_RL] > mag_next[WHEEL_RR]) ? mag_next[WHEEL_RL]
                                                              : mag_next[WHEEL_RR];
    mix_out.wheel  <= s2_wheel;
    mix_out.mag    <= s2_mag;
    mix_out.peak   <= peak_next;
    mix_out.scaled <= {{(LIMIT_W + 1){1'b0}}, peak_next} > {{(MAG_W + 1){1'b0}}, limit};
  end

endmodule

`default_nettype wire

/* sv/mwsl_div_step.sv */
// ----------------------------------------------------------------------------
// Divider step
// One restoring division step for all four wheels, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsl_div_step (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mwsl_pkg::div_stage_t stage_in,
  output mwsl_pkg::div_stage_t  stage_out
);
  import mwsl_pkg::*;

  div_lane_t [NUM_WHEELS-1:0] lane_next;
  logic [MAG_W:0]             trial [NUM_WHEELS];
  logic [MAG_W:0]             diff  [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]      fits;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      trial[i] = {stage_in.lane[i].rem, stage_in.lane[i].dq[QUOT_W-1]};
      diff[i]  = trial[i] - {1'b0, stage_in.peak};
      fits[i]  = trial[i] >= {1'b0, stage_in.peak};
      lane_next[i].neg   = stage_in.lane[i].neg;
      lane_next[i].wheel = stage_in.lane[i].wheel;
      lane_next[i].rem   = fits[i] ? diff[i][MAG_W-1:0] : trial[i][MAG_W-1:0];
      lane_next[i].dq    = {stage_in.lane[i].dq[QUOT_W-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.scaled <= stage_in.scaled;
    stage_out.peak   <= stage_in.peak;
    stage_out.lane   <= lane_next;
  end

endmodule

`default_nettype wire

/* sv/mecanum_wheel_speed_limiter_core.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel speed limiter
// Chassis command to four limited mecanum wheel speeds.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises, so
// a new command may follow in the very next cycle. Each request yields exactly
// one result, shown for one cycle with done high, after passing through the
// wheel mixing and peak search stages, the multiply register, one divider step
// per quotient bit of the 17-bit proportional scaling divider, and the output
// register. The results cannot be held off, so take them as they come.
// The limit register is written through cfg_valid/cfg_data (cfg_ready is
// always high) and must only change while no request is in flight.
`default_nettype none

module mecanum_wheel_speed_limiter_core (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst,
  input  wire  logic                                 start,
  output       logic                                 busy,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_forward,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_sideways,
  input  wire  logic signed [mwsl_pkg::SPEED_BITS-1:0] speed_rotate,
  input  wire  logic                                 cfg_valid,
  output       logic                                 cfg_ready,
  input  wire  logic [mwsl_pkg::LIMIT_W-1:0]         cfg_data,
  output       logic                                 done,
  output       logic signed [mwsl_pkg::WHEEL_W-1:0]  wheel_front_right,
  output       logic signed [mwsl_pkg::WHEEL_W-1:0]  wheel_front_left,
  output       logic signed [mwsl_pkg::WHEEL_W-1:0]  wheel_rear_left,
  output       logic signed [mwsl_pkg::WHEEL_W-1:0]  wheel_rear_right,
  output       logic                                 was_scaled
);
  import mwsl_pkg::*;

  logic [LIMIT_W-1:0]      limit;
  mix_out_t                mix_out;
  div_stage_t              div_pipe [QUOT_W+1];
  logic [PROD_W-1:0]       prod_next [NUM_WHEELS];
  wheel_t [NUM_WHEELS-1:0] final_next;
  logic [QUOT_W+WHEEL_W-1:0] quot_ext [NUM_WHEELS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  mwsl_mix u_mix (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (start && !busy),
    .speed_forward  (speed_forward),
    .speed_sideways (speed_sideways),
    .speed_rotate   (speed_rotate),
    .limit          (limit),
    .mix_out        (mix_out)
  );

  // Multiply stage: magnitude times limit, loaded as the divider's dividend.
  // The upper bits are below the peak whenever scaling applies, so they seed
  // the partial remainder directly.
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      prod_next[i] = PROD_W'(mix_out.mag[i]) * PROD_W'(limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else begin
      div_pipe[0].valid <= mix_out.valid;
    end
    div_pipe[0].scaled <= mix_out.scaled;
    div_pipe[0].peak   <= mix_out.peak;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      div_pipe[0].lane[i].neg   <= mix_out.wheel[i][WHEEL_W-1];
      div_pipe[0].lane[i].wheel <= mix_out.wheel[i];
      div_pipe[0].lane[i].rem   <= prod_next[i][PROD_W-1:QUOT_W];
      div_pipe[0].lane[i].dq    <= prod_next[i][QUOT_W-1:0];
    end
  end

  for (genvar g = 0; g < QUOT_W; g++) begin : g_div
    mwsl_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (div_pipe[g]),
      .stage_out (div_pipe[g+1])
    );
  end

  // Restore the sign on the quotient, or pass the wheel through unscaled.
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      quot_ext[i] = {{WHEEL_W{1'b0}}, div_pipe[QUOT_W].lane[i].dq};
      if (div_pipe[QUOT_W].scaled) begin
        final_next[i] = div_pipe[QUOT_W].lane[i].neg ? -quot_ext[i][WHEEL_W-1:0]
                                                     :  quot_ext[i][WHEEL_W-1:0];
      end else begin
        final_next[i] = div_pipe[QUOT_W].lane[i].wheel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_pipe[QUOT_W].valid;
    end
    wheel_front_right <= final_next[WHEEL_FR];
    wheel_front_left  <= final_next[WHEEL_FL];
    wheel_rear_left   <= final_next[WHEEL_RL];
    wheel_rear_right  <= final_next[WHEEL_RR];
    was_scaled        <= div_pipe[QUOT_W].scaled;
  end

endmodule

`default_nettype wire

/* bench/mecanum_wheel_speed_limiter_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum wheel speed limiter testbench
// Drives chassis velocity requests and limit register writes into the core,
// predicts the four wheel speeds and the scaled flag for every accepted
// request, and checks each result as it leaves the pipeline.
// ----------------------------------------------------------------------------

module mecanum_wheel_speed_limiter_core_test;
  import mwsl_pkg::*;

  typedef enum logic [1:0] {
    ITEM_CMD,
    ITEM_CFG,
    ITEM_DRAIN
  } item_kind_t;

  typedef struct {
    item_kind_t                    kind;
    logic signed [SPEED_BITS-1:0]  fwd;
    logic signed [SPEED_BITS-1:0]  side;
    logic signed [SPEED_BITS-1:0]  rot;
    logic [LIMIT_W-1:0]            limit;
  } bench_item_t;

  typedef struct packed {
    wheel_t fr;
    wheel_t fl;
    wheel_t rl;
    wheel_t rr;
    logic   scaled;
  } wheel_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SPEED_BITS-1:0] speed_forward = '0;
  logic signed [SPEED_BITS-1:0] speed_sideways = '0;
  logic signed [SPEED_BITS-1:0] speed_rotate = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic done;
  wheel_t wheel_front_right;
  wheel_t wheel_front_left;
  wheel_t wheel_rear_left;
  wheel_t wheel_rear_right;
  logic was_scaled;

  bench_item_t command_queue[$];
  wheel_set_t  wheels_due[$];
  logic [LIMIT_W-1:0] limit_copy = LIMIT_RESET;
  int mismatches = 0;
  int burst_left = 0;

  mecanum_wheel_speed_limiter_core dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .speed_forward     (speed_forward),
    .speed_sideways    (speed_sideways),
    .speed_rotate      (speed_rotate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .done              (done),
    .wheel_front_right (wheel_front_right),
    .wheel_front_left  (wheel_front_left),
    .wheel_rear_left   (wheel_rear_left),
    .wheel_rear_right  (wheel_rear_right),
    .was_scaled        (was_scaled)
  );

  always #2 clk = ~clk;

  // Mix the command into wheel speeds and scale them down when the peak
  // magnitude is strictly above the limit.
  function automatic wheel_set_t scale_wheels(input logic signed [SPEED_BITS-1:0] fwd,
                                              input logic signed [SPEED_BITS-1:0] side,
                                              input logic signed [SPEED_BITS-1:0] rot,
                                              input logic [LIMIT_W-1:0] limit);
    longint f, s, t, lim, peak, mag;
    longint w [NUM_WHEELS];
    wheel_set_t r;
    f = fwd;
    s = side;
    t = rot;
    lim = limit;
    w[WHEEL_FR] = -f - s - t;
    w[WHEEL_FL] = f - s - t;
    w[WHEEL_RL] = f + s - t;
    w[WHEEL_RR] = -f + s - t;
    peak = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) peak = mag;
    end
    r.scaled = (peak > lim);
    if (r.scaled) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        mag = (mag * lim) / peak;
        w[i] = (w[i] < 0) ? -mag : mag;
      end
    end
    r.fr = wheel_t'(w[WHEEL_FR]);
    r.fl = wheel_t'(w[WHEEL_FL]);
    r.rl = wheel_t'(w[WHEEL_RL]);
    r.rr = wheel_t'(w[WHEEL_RR]);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a back-to-back burst.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SPEED_BITS-1:0] pick_speed();
    logic signed [SPEED_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: v = {1'b1, {(SPEED_BITS-1){1'b0}}};
      1: v = {1'b0, {(SPEED_BITS-1){1'b1}}};
      2: v = '0;
      3, 4, 5: begin
        v = SPEED_BITS'($urandom_range(0, 400));
        v = v - 16'sd200;
      end
      default: v = SPEED_BITS'($urandom());
    endcase
    return v;
  endfunction

  task automatic add_cmd(input logic signed [SPEED_BITS-1:0] fwd,
                         input logic signed [SPEED_BITS-1:0] side,
                         input logic signed [SPEED_BITS-1:0] rot);
    bench_item_t it;
    it.kind = ITEM_CMD;
    it.fwd = fwd;
    it.side = side;
    it.rot = rot;
    it.limit = '0;
    command_queue.push_back(it);
  endtask

  task automatic add_cfg(input logic [LIMIT_W-1:0] limit);
    bench_item_t it;
    it.kind = ITEM_CFG;
    it.fwd = '0;
    it.side = '0;
    it.rot = '0;
    it.limit = limit;
    command_queue.push_back(it);
  endtask

  task automatic add_drain();
    bench_item_t it;
    it.kind = ITEM_DRAIN;
    it.fwd = '0;
    it.side = '0;
    it.rot = '0;
    it.limit = '0;
    command_queue.push_back(it);
  endtask

  // Split the limit over three same-signed speeds so that the front right
  // wheel lands exactly on the limit, or one above it.
  task automatic add_peak_at(input int lim, input int over);
    int a, c;
    a = lim / 3;
    c = lim - 2 * a + over;
    if ($urandom_range(0, 1))
      add_cmd(SPEED_BITS'(a), SPEED_BITS'(a), SPEED_BITS'(c));
    else
      add_cmd(SPEED_BITS'(-a), SPEED_BITS'(-a), SPEED_BITS'(-c));
  endtask

  always @(posedge clk) begin : driver
    logic cmd_pending;
    logic cfg_pending;
    logic next_start;
    logic next_cfg;
    int gap_left;
    int quiet_cycles;
    bench_item_t it;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      quiet_cycles = 0;
    end else begin
      if (start && !busy)
        wheels_due.push_back(scale_wheels(speed_forward, speed_sideways, speed_rotate,
                                          limit_copy));
      if (cfg_valid && cfg_ready)
        limit_copy = cfg_data;
      cmd_pending = start && busy;
      cfg_pending = cfg_valid && !cfg_ready;
      if (wheels_due.size() == 0 && !cmd_pending)
        quiet_cycles++;
      else
        quiet_cycles = 0;
      next_start = cmd_pending;
      next_cfg = cfg_pending;
      if (!cmd_pending && !cfg_pending) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (command_queue.size() > 0) begin
          it = command_queue[0];
          case (it.kind)
            ITEM_CMD: begin
              void'(command_queue.pop_front());
              speed_forward <= it.fwd;
              speed_sideways <= it.side;
              speed_rotate <= it.rot;
              next_start = 1'b1;
              gap_left = pick_gap();
            end
            // The limit may only change with no request in flight.
            ITEM_CFG: begin
              if (quiet_cycles >= 4) begin
                void'(command_queue.pop_front());
                cfg_data <= it.limit;
                next_cfg = 1'b1;
              end
            end
            ITEM_DRAIN: begin
              if (quiet_cycles >= 4)
                void'(command_queue.pop_front());
            end
            default: void'(command_queue.pop_front());
          endcase
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    wheel_set_t want;
    if (!rst && done) begin
      if (wheels_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = wheels_due.pop_front();
        if (wheel_front_right !== want.fr) begin
          $error("wheel_front_right: expected %0d, got %0d", want.fr, wheel_front_right);
          mismatches++;
        end
        if (wheel_front_left !== want.fl) begin
          $error("wheel_front_left: expected %0d, got %0d", want.fl, wheel_front_left);
          mismatches++;
        end
        if (wheel_rear_left !== want.rl) begin
          $error("wheel_rear_left: expected %0d, got %0d", want.rl, wheel_rear_left);
          mismatches++;
        end
        if (wheel_rear_right !== want.rr) begin
          $error("wheel_rear_right: expected %0d, got %0d", want.rr, wheel_rear_right);
          mismatches++;
        end
        if (was_scaled !== want.scaled) begin
          $error("was_scaled: expected %0d, got %0d", want.scaled, was_scaled);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int lim;
    // Directed part, starting from the reset limit.
    add_cmd(16'sd0, 16'sd0, 16'sd0);
    add_cmd(16'sd32767, 16'sd32767, 16'sd32767);
    add_cmd(-16'sd32768, -16'sd32768, -16'sd32768);  // peak equals the reset limit
    add_cmd(16'sd32767, -16'sd32768, 16'sd0);
    add_cmd(-16'sd32768, 16'sd32767, -16'sd32768);
    add_cmd(16'sd1, -16'sd1, 16'sd1);
    add_cfg(17'd0);
    add_cmd(16'sd0, 16'sd0, 16'sd0);
    add_cmd(16'sd5, -16'sd3, 16'sd7);
    add_cmd(-16'sd32768, 16'sd0, 16'sd0);
    add_cfg(17'd131071);
    add_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
    add_cmd(16'sd32767, -16'sd32768, 16'sd32767);
    add_cfg(17'd1000);
    add_cmd(16'sd1000, 16'sd0, 16'sd0);
    add_cmd(16'sd0, -16'sd1001, 16'sd0);
    add_cmd(16'sd300, -16'sd400, -16'sd300);
    add_cmd(-16'sd32768, 16'sd32767, -16'sd1);
    add_cfg(17'd1);
    add_cmd(16'sd1, 16'sd0, 16'sd0);
    add_cmd(16'sd0, 16'sd0, -16'sd2);
    add_cmd(16'sd12345, -16'sd23456, 16'sd345);
    add_cfg(17'd98304);
    add_cmd(-16'sd1, -16'sd1, -16'sd1);
    add_drain();

    // Random phases, each under its own limit setting.
    for (int phase = 0; phase < 11; phase++) begin
      case (phase % 6)
        0: lim = 0;
        1: lim = 98304;
        2: lim = 131071;
        3: lim = $urandom_range(1, 500);
        4: lim = $urandom_range(0, 131071);
        default: lim = $urandom_range(20000, 98303);
      endcase
      add_cfg(LIMIT_W'(lim));
      for (int n = 0; n < 48; n++) begin
        if (n == 20 && (phase == 0 || $urandom_range(0, 2) == 0))
          add_drain();
        if ((n == 10 || n == 30) && lim <= 98000) begin
          add_peak_at(lim, 0);
          add_peak_at(lim, 1);
        end else begin
          add_cmd(pick_speed(), pick_speed(), pick_speed());
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (command_queue.size() != 0 || start || cfg_valid || wheels_due.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && wheels_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
